>>> hw/rtl/sga_pkg.sv
// Shared types and constants of the softened gravity engine.
// No dependencies; used by every module of the block.
package sga_pkg;

  localparam int MAX_BODIES_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  // squared distance word, inverse-power result, product widths
  localparam int D_W    = 68;
  localparam int R_W    = 64;
  localparam int AB_W   = 33;
  localparam int MM_W   = 65;
  localparam int PROD_W = MM_W + R_W;
  localparam int TERM_W = 57;
  localparam int ACC_W  = 48;

  localparam logic [TERM_W-1:0] TERM_LIM = TERM_W'(1) << 56;

  // configuration register indexes
  localparam logic [7:0] REG_BODY_COUNT = 8'd0;
  localparam logic [7:0] REG_SOFTENING  = 8'd1;

  typedef struct packed {
    logic        is_query;
    logic        load_ok;
    logic [5:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] m;
  } item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } front_stat_t;

endpackage

>>> hw/rtl/sga_front.sv
// Front end: takes command beats, decodes them and holds them in a two-entry queue.
// Depends on sga_pkg.
module sga_front #(
  parameter int MAX_BODIES = sga_pkg::MAX_BODIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 func,
  input  logic [5:0]           body_index,
  input  logic [31:0]          pos_x,
  input  logic [31:0]          pos_y,
  input  logic [31:0]          pos_z,
  input  logic [31:0]          body_mass,
  input  logic                 pop,
  output logic                 item_valid,
  output sga_pkg::item_t       item,
  output sga_pkg::front_stat_t stat
);

  sga_pkg::item_t q [2];
  sga_pkg::item_t new_item;
  logic           wp;
  logic           rp;
  logic [1:0]     count;
  logic           push;

  assign stat.count = count;
  assign stat.full  = (count == 2'd2);
  assign push       = start & ~stat.full;
  assign item_valid = (count != 2'd0);
  assign item       = q[rp];

  always_comb begin
    new_item.is_query = func;
    new_item.load_ok  = (32'(body_index) < 32'(MAX_BODIES));
    new_item.idx      = body_index;
    new_item.x        = pos_x;
    new_item.y        = pos_y;
    new_item.z        = pos_z;
    new_item.m        = body_mass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= new_item;
  end

endmodule

>>> hw/rtl/sga_invpow.sv
// Bit-serial inverse 1.5 power: floor(sqrt(2^(2P) / D^3)), P = 32 + 3*FRAC_BITS.
// Three restoring divisions by D, then a digit-by-digit square root. Depends on sga_pkg.
module sga_invpow #(
  parameter int FRAC_BITS = sga_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [sga_pkg::D_W-1:0]   d_in,
  output logic                      done,
  output logic [sga_pkg::R_W-1:0]   r
);

  localparam int P     = 32 + 3 * FRAC_BITS;
  localparam int NUM_W = 2 * P + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int QX_W  = (NUM_W > 129) ? NUM_W : 129;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]              st;
  logic [NUM_W-1:0]        num;
  logic [sga_pkg::D_W-1:0] rem;
  logic [sga_pkg::D_W-1:0] d;
  logic [CNT_W-1:0]        cnt;
  logic [1:0]              pass;
  logic [127:0]            qs;
  logic [65:0]             srem;
  logic [63:0]             root;

  logic [sga_pkg::D_W:0]   rem_sh;
  logic                    ge;
  logic [sga_pkg::D_W:0]   rem_diff;
  logic [QX_W-1:0]         qx;
  logic [67:0]             srem_sh;
  logic [67:0]             trial;
  logic                    ge2;

  always_comb begin
    rem_sh   = {rem, num[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, d});
    rem_diff = rem_sh - {1'b0, d};
    qx       = QX_W'(num);
    srem_sh  = {srem, qs[127:126]};
    trial    = {2'b00, root, 2'b01};
    ge2      = (srem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (go) st <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CNT_W'(NUM_W - 1) && pass == 2'd2) st <= S_PREP;
        end
        S_PREP: begin
          if (|qx[QX_W-1:128]) begin
            done <= 1'b1;
            st   <= S_IDLE;
          end else begin
            st <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt == CNT_W'(63)) st <= S_FIN;
        end
        S_FIN: begin
          done <= 1'b1;
          st   <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        d    <= d_in;
        num  <= NUM_W'(1) << (2 * P);
        rem  <= '0;
        cnt  <= '0;
        pass <= 2'd0;
      end
      S_DIV: begin
        num <= {num[NUM_W-2:0], ge};
        cnt <= cnt + CNT_W'(1);
        rem <= ge ? rem_diff[sga_pkg::D_W-1:0] : rem_sh[sga_pkg::D_W-1:0];
        if (cnt == CNT_W'(NUM_W - 1)) begin
          cnt  <= '0;
          rem  <= '0;
          pass <= pass + 2'd1;
        end
      end
      S_PREP: begin
        qs   <= qx[127:0];
        srem <= '0;
        root <= '0;
        cnt  <= '0;
        r    <= '1;
      end
      S_SQRT: begin
        qs  <= {qs[125:0], 2'b00};
        cnt <= cnt + CNT_W'(1);
        if (ge2) begin
          srem <= 66'(srem_sh - trial);
          root <= {root[62:0], 1'b1};
        end else begin
          srem <= srem_sh[65:0];
          root <= {root[62:0], 1'b0};
        end
      end
      S_FIN: r <= root;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/sga_back.sv
// Back end: body store, per-body sequencer, bit-serial term multiply, sums and output.
// Depends on sga_pkg and sga_invpow.
module sga_back #(
  parameter int MAX_BODIES = sga_pkg::MAX_BODIES_DEF,
  parameter int FRAC_BITS  = sga_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  sga_pkg::item_t        item,
  output logic                  pop,
  input  logic [6:0]            body_count,
  input  logic [31:0]           soft_len_sq,
  output logic                  done,
  output logic [47:0]           accel_x,
  output logic [47:0]           accel_y,
  output logic [47:0]           accel_z,
  output logic                  saturated
);

  localparam int AW  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CW  = $clog2(MAX_BODIES + 1);
  localparam int S_W = sga_pkg::TERM_W + CW + 1;
  localparam int SH  = 32 + FRAC_BITS;
  localparam logic signed [S_W-1:0] AMAX = S_W'((64'sd1 <<< 47) - 64'sd1);
  localparam logic signed [S_W-1:0] AMIN = S_W'(-(64'sd1 <<< 47));

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_READ = 4'd1;
  localparam logic [3:0] B_OFF  = 4'd2;
  localparam logic [3:0] B_SQ   = 4'd3;
  localparam logic [3:0] B_INV  = 4'd4;
  localparam logic [3:0] B_MM   = 4'd5;
  localparam logic [3:0] B_MUL  = 4'd6;
  localparam logic [3:0] B_ACC  = 4'd7;
  localparam logic [3:0] B_NEXT = 4'd8;
  localparam logic [3:0] B_FIN  = 4'd9;

  logic [127:0] mem [MAX_BODIES];
  logic [127:0] rdata;
  logic [31:0]  waddr_ext;

  logic [3:0]                   st;
  logic [CW-1:0]                k;
  logic [CW-1:0]                n;
  logic [CW-1:0]                n_lim;
  logic [31:0]                  px, py, pz;
  logic [sga_pkg::AB_W-1:0]     ab   [3];
  logic                         neg  [3];
  logic [31:0]                  m;
  logic [1:0]                   ax;
  logic [sga_pkg::D_W-1:0]      dacc;
  logic [sga_pkg::R_W-1:0]      rsh;
  logic [sga_pkg::PROD_W-1:0]   mms  [3];
  logic [sga_pkg::PROD_W-1:0]   prod [3];
  logic [5:0]                   bcnt;
  logic signed [S_W-1:0]        sum  [3];
  logic                         sat;
  logic                         ip_go;
  logic                         ip_done;
  logic [sga_pkg::R_W-1:0]      ip_r;

  // offsets of the fetched body from the query point
  logic signed [sga_pkg::AB_W-1:0] off [3];
  logic [sga_pkg::AB_W-1:0]        off_abs [3];
  logic [31:0]                     rpos [3];
  logic [31:0]                     qpos [3];
  logic                            skip;
  logic [sga_pkg::PROD_W-SH-1:0]   qt   [3];
  logic [sga_pkg::TERM_W-1:0]      tv   [3];
  logic                            tclip [3];
  logic [2*sga_pkg::AB_W-1:0]      sq;

  sga_invpow #(.FRAC_BITS(FRAC_BITS)) u_invpow (
    .clk  (clk),
    .rst  (rst),
    .go   (ip_go),
    .d_in (dacc),
    .done (ip_done),
    .r    (ip_r)
  );

  assign pop       = item_valid && (st == B_IDLE);
  assign waddr_ext = 32'(item.idx);

  always_comb begin
    if (32'(body_count) > 32'(MAX_BODIES)) n_lim = CW'(MAX_BODIES);
    else                                   n_lim = CW'(body_count);
    rpos[0] = rdata[127:96];
    rpos[1] = rdata[95:64];
    rpos[2] = rdata[63:32];
    qpos[0] = px;
    qpos[1] = py;
    qpos[2] = pz;
    for (int j = 0; j < 3; j++) begin
      off[j]     = $signed({rpos[j][31], rpos[j]}) - $signed({qpos[j][31], qpos[j]});
      off_abs[j] = off[j][sga_pkg::AB_W-1] ? sga_pkg::AB_W'(-off[j])
                                          : sga_pkg::AB_W'(off[j]);
      qt[j]      = prod[j][sga_pkg::PROD_W-1:SH];
      tclip[j]   = (qt[j] > (sga_pkg::PROD_W-SH)'(sga_pkg::TERM_LIM));
      tv[j]      = tclip[j] ? sga_pkg::TERM_LIM : sga_pkg::TERM_W'(qt[j]);
    end
    skip = (rdata[31:0] == 32'd0) ||
           (off[0] == '0 && off[1] == '0 && off[2] == '0);
    sq   = ab[ax] * ab[ax];
  end

  // body store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pop && !item.is_query && item.load_ok)
      mem[waddr_ext[AW-1:0]] <= {item.x, item.y, item.z, item.m};
    rdata <= mem[k[AW-1:0]];
  end

  // ip_go pulses in the first B_INV cycle, once dacc holds the full sum
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= B_IDLE;
      done  <= 1'b0;
      ip_go <= 1'b0;
    end else begin
      done  <= 1'b0;
      ip_go <= (st == B_SQ) && (ax == 2'd2);
      case (st)
        B_IDLE: begin
          if (pop && item.is_query) st <= (n_lim == '0) ? B_FIN : B_READ;
        end
        B_READ: st <= B_OFF;
        B_OFF:  st <= skip ? B_NEXT : B_SQ;
        B_SQ:   if (ax == 2'd2) st <= B_INV;
        B_INV:  if (ip_done) st <= B_MM;
        B_MM:   if (ax == 2'd2) st <= B_MUL;
        B_MUL:  if (bcnt == 6'd63) st <= B_ACC;
        B_ACC:  st <= B_NEXT;
        B_NEXT: st <= ((k + CW'(1)) == n) ? B_FIN : B_READ;
        B_FIN: begin
          done <= 1'b1;
          st   <= B_IDLE;
        end
        default: st <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      B_IDLE: begin
        px  <= item.x;
        py  <= item.y;
        pz  <= item.z;
        n   <= n_lim;
        k   <= '0;
        sat <= 1'b0;
        for (int j = 0; j < 3; j++) sum[j] <= '0;
      end
      B_OFF: begin
        for (int j = 0; j < 3; j++) begin
          ab[j]  <= off_abs[j];
          neg[j] <= off[j][sga_pkg::AB_W-1];
        end
        m    <= rdata[31:0];
        dacc <= sga_pkg::D_W'(soft_len_sq) << FRAC_BITS;
        ax   <= 2'd0;
      end
      B_SQ: begin
        dacc <= dacc + sga_pkg::D_W'(sq);
        ax   <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
      end
      B_INV: begin
        rsh <= ip_r;
        if (ip_done && ip_r == '1) sat <= 1'b1;
      end
      B_MM: begin
        mms[ax]  <= sga_pkg::PROD_W'({33'd0, m} * {32'd0, ab[ax]});
        prod[ax] <= '0;
        ax       <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        bcnt     <= 6'd0;
      end
      B_MUL: begin
        for (int j = 0; j < 3; j++) begin
          if (rsh[0]) prod[j] <= prod[j] + mms[j];
          mms[j] <= {mms[j][sga_pkg::PROD_W-2:0], 1'b0};
        end
        rsh  <= {1'b0, rsh[sga_pkg::R_W-1:1]};
        bcnt <= bcnt + 6'd1;
      end
      B_ACC: begin
        for (int j = 0; j < 3; j++) begin
          if (neg[j]) sum[j] <= sum[j] - $signed(S_W'(tv[j]));
          else        sum[j] <= sum[j] + $signed(S_W'(tv[j]));
          if (tclip[j]) sat <= 1'b1;
        end
      end
      B_NEXT: k <= k + CW'(1);
      B_FIN: begin
        saturated <= sat ||
                     sum[0] > AMAX || sum[0] < AMIN ||
                     sum[1] > AMAX || sum[1] < AMIN ||
                     sum[2] > AMAX || sum[2] < AMIN;
        accel_x <= (sum[0] > AMAX) ? AMAX[47:0] : (sum[0] < AMIN) ? AMIN[47:0] : sum[0][47:0];
        accel_y <= (sum[1] > AMAX) ? AMAX[47:0] : (sum[1] < AMIN) ? AMIN[47:0] : sum[1][47:0];
        accel_z <= (sum[2] > AMAX) ? AMAX[47:0] : (sum[2] < AMIN) ? AMIN[47:0] : sum[2][47:0];
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/softened_gravity_acceleration.sv
// Top level of the softened direct-sum gravity engine.
// Depends on sga_pkg, sga_front, sga_back (and sga_invpow below it).

// A command beat is taken when start is high and busy is low. func 0 loads one
// body (position, mass) into slot body_index; slots at or above MAX_BODIES are
// dropped. func 1 queries the point pos_x/y/z and, when done, yields one result
// beat: done is high for exactly one cycle with accel_x/y/z and saturated valid
// in that cycle. The receiver cannot stall: sample on done or lose the beat.
// Commands go through a two-entry queue, so busy rises only when it is full;
// results come out in command order. A load is written to the body store as
// it is popped. A query sums slots in turn; a slot that adds nothing (zero
// mass or at the query point) is passed over, and any other slot runs the
// bit-serial inverse-power unit, P = 32 + 3*FRAC_BITS (80 at Q16.16): three
// restoring divisions of a (2P+1)-bit dividend, one bit a cycle, then a
// 64-step square root; a shift-add multiply of mass, offset and the result
// gives each term, which is added to the sums. Configuration:
// cfg_ready is always high; index 0 is body_count, 1 is soft_len_sq, other
// indexes are ignored. Write only while no query is in flight. Slots never
// loaded since reset must not be summed.
module softened_gravity_acceleration #(
  parameter int MAX_BODIES = sga_pkg::MAX_BODIES_DEF,
  parameter int FRAC_BITS  = sga_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command beats
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [5:0]  body_index,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] body_mass,
  // result beats
  output logic        done,
  output logic [47:0] accel_x,
  output logic [47:0] accel_y,
  output logic [47:0] accel_z,
  output logic        saturated,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [6:0]           body_count;
  logic [31:0]          soft_len_sq;
  logic                 item_valid;
  logic                 pop;
  sga_pkg::item_t       item;
  sga_pkg::front_stat_t fstat;

  assign cfg_ready = 1'b1;
  assign busy      = fstat.full;

  // config registers; softening resets to 0.25
  always_ff @(posedge clk) begin
    if (rst) begin
      body_count  <= 7'd0;
      soft_len_sq <= 32'd1 << (FRAC_BITS - 2);
    end else if (cfg_valid) begin
      case (cfg_index)
        sga_pkg::REG_BODY_COUNT: body_count  <= cfg_data[6:0];
        sga_pkg::REG_SOFTENING:  soft_len_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  sga_front #(.MAX_BODIES(MAX_BODIES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .body_index (body_index),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .body_mass  (body_mass),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item),
    .stat       (fstat)
  );

  sga_back #(.MAX_BODIES(MAX_BODIES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .pop          (pop),
    .body_count   (body_count),
    .soft_len_sq  (soft_len_sq),
    .done         (done),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .saturated    (saturated)
  );

  // done drops again after each result beat; it is never held high
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // queue comes out of reset empty, so commands are taken at once
  a_reset_ready: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !busy)
    else $error("busy right after reset");

  // busy only when the queue really holds two entries
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
                                busy |-> fstat.count == 2'd2)
    else $error("busy without a full queue");

  // the back end only pops what the queue holds
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> item_valid)
    else $error("pop from empty queue");

endmodule
